FILE: rtl/kcc_pkg.sv
// Shared types and codes for the kanji code converter.
package kcc_pkg;

	// encoding codes for input_code / output_code
	localparam logic [2:0] CODE_EUC      = 3'd0;
	localparam logic [2:0] CODE_SJIS     = 3'd1;
	localparam logic [2:0] CODE_JIS_AT_H = 3'd2;
	localparam logic [2:0] CODE_JIS_AT_J = 3'd3;
	localparam logic [2:0] CODE_JIS_AT_B = 3'd4;
	localparam logic [2:0] CODE_JIS_B_H  = 3'd5;
	localparam logic [2:0] CODE_JIS_B_J  = 3'd6;
	localparam logic [2:0] CODE_JIS_B_B  = 3'd7;

	// configuration register indexes
	localparam logic [1:0] REG_INPUT_CODE  = 2'd0;
	localparam logic [1:0] REG_OUTPUT_CODE = 2'd1;
	localparam logic [1:0] REG_KANJI_BS_EN = 2'd2;

	// decoder modes
	localparam int         MODE_W      = 4;
	localparam logic [3:0] MODE_ASCII  = 4'd0;
	localparam logic [3:0] MODE_LEAD   = 4'd1;
	localparam logic [3:0] MODE_TRAIL  = 4'd2;
	localparam logic [3:0] MODE_ESC    = 4'd3;
	localparam logic [3:0] MODE_KESC   = 4'd4;
	localparam logic [3:0] MODE_ESCDL  = 4'd5;
	localparam logic [3:0] MODE_ESCPAR = 4'd6;
	localparam logic [3:0] MODE_KESCDL = 4'd7;
	localparam logic [3:0] MODE_KESCPR = 4'd8;

	// special bytes
	localparam logic [7:0] ESC_BYTE    = 8'h1b;
	localparam logic [7:0] BS_BYTE     = 8'h08;
	localparam logic [7:0] DOLLAR_BYTE = 8'h24;
	localparam logic [7:0] PAREN_BYTE  = 8'h28;
	localparam logic [7:0] AT_BYTE     = 8'h40;
	localparam logic [7:0] B_BYTE      = 8'h42;
	localparam logic [7:0] H_BYTE      = 8'h48;
	localparam logic [7:0] J_BYTE      = 8'h4a;
	localparam logic [7:0] DEL_BYTE    = 8'h7f;
	localparam logic [7:0] SPACE_BYTE  = 8'h20;

	typedef struct packed {
		logic [2:0] input_code;
		logic [2:0] output_code;
		logic       kanji_backspace_enable;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [7:0]        lead;
	} dec_state_t;

	// up to four output bytes caused by one input byte
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      count;
	} run_t;

endpackage

FILE: rtl/kcc_if.sv
// Valid/ready channel interfaces for input and output bytes.
interface kcc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface kcc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: rtl/kcc_decoder.sv
// Decoder: next mode and output run for one input byte.
module kcc_decoder (
	input  kcc_pkg::cfg_t       cfg,
	input  kcc_pkg::dec_state_t state_cur,
	input  logic [7:0]          in_byte,
	output kcc_pkg::dec_state_t state_nxt,
	output kcc_pkg::run_t       run
);

	localparam logic [2:0] EMIT_NONE  = 3'd0;
	localparam logic [2:0] EMIT_BYTE  = 3'd1;
	localparam logic [2:0] EMIT_PAIR  = 3'd2;
	localparam logic [2:0] EMIT_ESC   = 3'd3;
	localparam logic [2:0] EMIT_KIN   = 3'd4;
	localparam logic [2:0] EMIT_LEAVE = 3'd5;

	logic       in_jis;
	logic       out_jis;
	logic [2:0] emit;
	logic [7:0] kin_last;
	logic [7:0] kout_last;
	logic [7:0] c_hi, c_lo, d_hi, d_lo, sj_hi, sj_lo;
	logic [7:0] e_hi, e_lo;
	logic [7:0] conv_hi, conv_lo;

	assign in_jis  = cfg.input_code >= kcc_pkg::CODE_JIS_AT_H;
	assign out_jis = cfg.output_code >= kcc_pkg::CODE_JIS_AT_H;

	// final byte of the kanji-in and kanji-out escapes
	always_comb begin
		case (cfg.output_code) inside
			kcc_pkg::CODE_JIS_AT_H, kcc_pkg::CODE_JIS_AT_J,
			kcc_pkg::CODE_JIS_AT_B: kin_last = kcc_pkg::AT_BYTE;
			default:                kin_last = kcc_pkg::B_BYTE;
		endcase
		case (cfg.output_code) inside
			kcc_pkg::CODE_JIS_AT_H, kcc_pkg::CODE_JIS_B_H: kout_last = kcc_pkg::H_BYTE;
			kcc_pkg::CODE_JIS_AT_J, kcc_pkg::CODE_JIS_B_J: kout_last = kcc_pkg::J_BYTE;
			default:                                       kout_last = kcc_pkg::B_BYTE;
		endcase
	end

	// kanji pair conversion, all arithmetic mod 256
	always_comb begin
		c_hi = state_cur.lead & 8'h7f;
		c_lo = in_byte & 8'h7f;
		// JIS row/cell to Shift-JIS
		d_hi = c_hi - 8'h20;
		d_lo = c_lo - 8'h20;
		if (!d_hi[0])
			d_lo = d_lo + 8'd94;
		if (d_hi == 8'h00)
			sj_hi = 8'h80;
		else
			sj_hi = ((d_hi - 8'd1) >> 1) + 8'h81;
		sj_lo = d_lo + 8'h3f;
		if (sj_hi > 8'h9f)
			sj_hi = sj_hi + 8'h40;
		if (sj_lo > 8'h7e)
			sj_lo = sj_lo + 8'd1;
		// Shift-JIS to JIS row/cell
		e_hi = (state_cur.lead > 8'h9f) ? state_cur.lead - 8'h40 : state_cur.lead;
		e_hi = (e_hi - 8'h81) << 1;
		e_lo = (in_byte > 8'h7e) ? in_byte - 8'd1 : in_byte;
		if (e_lo > 8'h9d) begin
			e_lo = e_lo - 8'h9d;
			e_hi = e_hi + 8'd2;
		end else begin
			e_lo = e_lo - 8'h3f;
			e_hi = e_hi + 8'd1;
		end

		if (cfg.input_code == cfg.output_code || (in_jis && out_jis)) begin
			conv_hi = state_cur.lead;
			conv_lo = in_byte;
		end else if (cfg.input_code != kcc_pkg::CODE_SJIS) begin
			if (out_jis) begin
				conv_hi = c_hi;
				conv_lo = c_lo;
			end else if (cfg.output_code == kcc_pkg::CODE_EUC) begin
				conv_hi = c_hi | 8'h80;
				conv_lo = c_lo | 8'h80;
			end else begin
				conv_hi = sj_hi;
				conv_lo = sj_lo;
			end
		end else if (cfg.output_code == kcc_pkg::CODE_EUC) begin
			conv_hi = e_hi + 8'ha0;
			conv_lo = e_lo + 8'ha0;
		end else begin
			conv_hi = e_hi + kcc_pkg::SPACE_BYTE;
			conv_lo = e_lo + kcc_pkg::SPACE_BYTE;
		end
	end

	// mode transitions
	always_comb begin
		state_nxt = state_cur;
		emit      = EMIT_NONE;
		if (!in_jis) begin
			unique case (state_cur.mode)
				kcc_pkg::MODE_LEAD: begin
					state_nxt.mode = kcc_pkg::MODE_TRAIL;
					emit           = EMIT_PAIR;
				end
				kcc_pkg::MODE_TRAIL: begin
					if (in_byte[7]) begin
						state_nxt.mode = kcc_pkg::MODE_LEAD;
						state_nxt.lead = in_byte;
					end else if (cfg.kanji_backspace_enable && in_byte == kcc_pkg::BS_BYTE) begin
						emit = EMIT_BYTE;
					end else begin
						state_nxt.mode = kcc_pkg::MODE_ASCII;
						emit           = EMIT_LEAVE;
					end
				end
				default: begin
					// escape modes left over from a JIS setting read as ascii
					if (in_byte[7]) begin
						state_nxt.mode = kcc_pkg::MODE_LEAD;
						state_nxt.lead = in_byte;
						emit           = EMIT_KIN;
					end else begin
						state_nxt.mode = kcc_pkg::MODE_ASCII;
						emit           = EMIT_BYTE;
					end
				end
			endcase
		end else begin
			unique case (state_cur.mode)
				kcc_pkg::MODE_LEAD: begin
					if (in_byte != kcc_pkg::ESC_BYTE) begin
						state_nxt.mode = kcc_pkg::MODE_TRAIL;
						emit           = EMIT_PAIR;
					end
				end
				kcc_pkg::MODE_TRAIL: begin
					if (in_byte == kcc_pkg::ESC_BYTE) begin
						state_nxt.mode = kcc_pkg::MODE_KESC;
					end else if (cfg.kanji_backspace_enable && in_byte == kcc_pkg::BS_BYTE) begin
						emit = EMIT_BYTE;
					end else if (in_byte < kcc_pkg::SPACE_BYTE || in_byte == kcc_pkg::DEL_BYTE) begin
						state_nxt.mode = kcc_pkg::MODE_ASCII;
						emit           = EMIT_LEAVE;
					end else begin
						state_nxt.mode = kcc_pkg::MODE_LEAD;
						state_nxt.lead = in_byte;
					end
				end
				kcc_pkg::MODE_ESC: begin
					if (in_byte == kcc_pkg::DOLLAR_BYTE) begin
						state_nxt.mode = kcc_pkg::MODE_ESCDL;
					end else if (in_byte == kcc_pkg::PAREN_BYTE) begin
						state_nxt.mode = kcc_pkg::MODE_ESCPAR;
					end else begin
						state_nxt.mode = kcc_pkg::MODE_ASCII;
						emit           = EMIT_ESC;
					end
				end
				kcc_pkg::MODE_KESC: begin
					if (in_byte == kcc_pkg::PAREN_BYTE) begin
						state_nxt.mode = kcc_pkg::MODE_KESCPR;
					end else if (in_byte == kcc_pkg::DOLLAR_BYTE) begin
						state_nxt.mode = kcc_pkg::MODE_KESCDL;
					end else begin
						// unknown escape inside kanji: wait for a trail on the held lead
						state_nxt.mode = kcc_pkg::MODE_LEAD;
						emit           = EMIT_ESC;
					end
				end
				kcc_pkg::MODE_ESCDL: begin
					state_nxt.mode = kcc_pkg::MODE_TRAIL;
					emit           = EMIT_KIN;
				end
				kcc_pkg::MODE_KESCPR: begin
					state_nxt.mode = kcc_pkg::MODE_ASCII;
					emit           = EMIT_LEAVE;
				end
				kcc_pkg::MODE_ESCPAR: begin
					state_nxt.mode = kcc_pkg::MODE_ASCII;
				end
				kcc_pkg::MODE_KESCDL: begin
					state_nxt.mode = kcc_pkg::MODE_TRAIL;
				end
				default: begin
					if (in_byte == kcc_pkg::ESC_BYTE) begin
						state_nxt.mode = kcc_pkg::MODE_ESC;
					end else begin
						state_nxt.mode = kcc_pkg::MODE_ASCII;
						emit           = EMIT_BYTE;
					end
				end
			endcase
		end
	end

	// the byte after ESC ( in kanji is consumed, so a JIS leave carries no byte of its own
	logic leave_has_byte;
	assign leave_has_byte = !(in_jis && state_cur.mode == kcc_pkg::MODE_KESCPR);

	always_comb begin
		run = '0;
		unique case (emit)
			EMIT_BYTE: begin
				run.data[0] = in_byte;
				run.count   = 3'd1;
			end
			EMIT_PAIR: begin
				run.data[0] = conv_hi;
				run.data[1] = conv_lo;
				run.count   = 3'd2;
			end
			EMIT_ESC: begin
				run.data[0] = kcc_pkg::ESC_BYTE;
				run.data[1] = in_byte;
				run.count   = 3'd2;
			end
			EMIT_KIN: begin
				if (out_jis) begin
					run.data[0] = kcc_pkg::ESC_BYTE;
					run.data[1] = kcc_pkg::DOLLAR_BYTE;
					run.data[2] = kin_last;
					run.count   = 3'd3;
				end
			end
			EMIT_LEAVE: begin
				if (out_jis) begin
					run.data[0] = kcc_pkg::ESC_BYTE;
					run.data[1] = kcc_pkg::PAREN_BYTE;
					run.data[2] = kout_last;
					run.data[3] = in_byte;
					run.count   = leave_has_byte ? 3'd4 : 3'd3;
				end else if (leave_has_byte) begin
					run.data[0] = in_byte;
					run.count   = 3'd1;
				end
			end
			default: begin
				run = '0;
			end
		endcase
	end

endmodule

FILE: rtl/kcc_run_fifo.sv
// Two-entry run buffer that unloads one output word per cycle while the receiver is ready.
module kcc_run_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  kcc_pkg::run_t     push_run,
	output logic              full,
	kcc_out_if.source         out_chan
);

	kcc_pkg::run_t mem [2];
	kcc_pkg::run_t head;
	logic [1:0]    cnt_q;
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    idx_q;
	logic          step;
	logic          pop;
	logic          last;

	assign head                 = mem[rd_q];
	assign full                 = cnt_q == 2'd2;
	assign last                 = {1'b0, idx_q} == head.count - 3'd1;
	assign out_chan.valid       = cnt_q != 2'd0;
	assign out_chan.out_byte    = head.data[idx_q];
	assign out_chan.last_of_run = last;
	assign step                 = out_chan.valid && out_chan.ready;
	assign pop                  = step && last;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (step)
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("run pushed into full buffer");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_run.count != 3'd0 && push_run.count <= 3'd4))
		else $error("run pushed with bad word count");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !last) |=> (out_chan.valid && idx_q != 2'd0))
		else $error("run dropped before its last word");

endmodule

FILE: rtl/kanji_code_converter_top.sv
// Top level of the kanji code converter: input stage, decoder state, run buffer.
// Data path: an accepted byte is registered in the input stage, decoded combinationally,
// and its run is registered into the run buffer, which presents its output words.
// Throughput: one output word per cycle on the byte-wide result port while the receiver
// is ready; bytes that cause n words (n up to 4) hold back later input while the run
// buffer is full, and bytes that cause zero or one word flow at one per cycle.
// Reset: ascii mode, lead byte zero, configuration zero, buffers empty.
module kanji_code_converter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_wdata,
	kcc_in_if.sink     in_chan,
	kcc_out_if.source  out_chan
);

	kcc_pkg::cfg_t       cfg_q;
	kcc_pkg::dec_state_t state_q;
	kcc_pkg::dec_state_t state_nxt;
	kcc_pkg::run_t       run;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                full;
	logic                advance;
	logic                push;
	logic                in_take;

	assign advance       = valid_s1 && (run.count == 3'd0 || !full);
	assign push          = advance && run.count != 3'd0;
	assign in_chan.ready = !valid_s1 || advance;
	assign in_take       = in_chan.valid && in_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kcc_pkg::REG_INPUT_CODE:  cfg_q.input_code <= cfg_wdata;
				kcc_pkg::REG_OUTPUT_CODE: cfg_q.output_code <= cfg_wdata;
				kcc_pkg::REG_KANJI_BS_EN: cfg_q.kanji_backspace_enable <= cfg_wdata[0];
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{mode: kcc_pkg::MODE_ASCII, lead: 8'h00};
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			byte_s1 <= in_chan.in_byte;
	end

	kcc_decoder u_decoder (
		.cfg       (cfg_q),
		.state_cur (state_q),
		.in_byte   (byte_s1),
		.state_nxt (state_nxt),
		.run       (run)
	);

	kcc_run_fifo u_run_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (run),
		.full     (full),
		.out_chan (out_chan)
	);

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(state_q)))
		else $error("stalled byte or state changed");

	a_four_needs_jis: assert property (@(posedge clk) disable iff (!arst_n)
		(push && run.count == 3'd4) |-> cfg_q.output_code >= kcc_pkg::CODE_JIS_AT_H)
		else $error("four-word run without JIS output");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_chan.ready)
		else $error("input held off with an empty stage");

endmodule

FILE: test/tb_kanji_code_converter_top.sv
// Testbench for kanji_code_converter_top: random and directed byte streams vs a predictor.
`timescale 1ns / 1ps

module tb_kanji_code_converter_top;

	localparam int LONG_HOLD = 300;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} out_word_t;

	// Tracks decoder state and config, keeps the words each accepted byte should produce.
	class kanji_scoreboard;
		logic [2:0]  in_code;
		logic [2:0]  out_code;
		logic        bs_en;
		logic [3:0]  mode;
		logic [7:0]  lead;
		logic [7:0]  run[$];
		out_word_t   expected_q[$];
		int          errors;

		function new();
			in_code  = kcc_pkg::CODE_EUC;
			out_code = kcc_pkg::CODE_EUC;
			bs_en    = 1'b0;
			mode     = kcc_pkg::MODE_ASCII;
			lead     = 8'h00;
			errors   = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [2:0] val);
			case (idx)
				kcc_pkg::REG_INPUT_CODE:  in_code = val;
				kcc_pkg::REG_OUTPUT_CODE: out_code = val;
				kcc_pkg::REG_KANJI_BS_EN: bs_en = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void emit(logic [7:0] b);
			if (run.size() < 4)
				run.push_back(b);
		endfunction

		function void kanji_in();
			if (out_code >= kcc_pkg::CODE_JIS_AT_H) begin
				emit(kcc_pkg::ESC_BYTE);
				emit(kcc_pkg::DOLLAR_BYTE);
				emit(out_code <= kcc_pkg::CODE_JIS_AT_B ? kcc_pkg::AT_BYTE : kcc_pkg::B_BYTE);
			end
		endfunction

		function void kanji_out();
			if (out_code >= kcc_pkg::CODE_JIS_AT_H) begin
				emit(kcc_pkg::ESC_BYTE);
				emit(kcc_pkg::PAREN_BYTE);
				case (out_code)
					kcc_pkg::CODE_JIS_AT_H, kcc_pkg::CODE_JIS_B_H: emit(kcc_pkg::H_BYTE);
					kcc_pkg::CODE_JIS_AT_J, kcc_pkg::CODE_JIS_B_J: emit(kcc_pkg::J_BYTE);
					default: emit(kcc_pkg::B_BYTE);
				endcase
			end
		endfunction

		function void leave_kanji(logic [7:0] c);
			mode = kcc_pkg::MODE_ASCII;
			kanji_out();
			emit(c);
		endfunction

		// row/cell mapping between EUC/JIS and Shift-JIS, all 8-bit wrapping
		function void convert_pair(logic [7:0] a, logic [7:0] b);
			logic [7:0] c1;
			logic [7:0] c2;
			c1 = a;
			c2 = b;
			if (in_code == out_code || (in_code >= kcc_pkg::CODE_JIS_AT_H &&
					out_code >= kcc_pkg::CODE_JIS_AT_H)) begin
				emit(c1);
				emit(c2);
			end else if (in_code != kcc_pkg::CODE_SJIS) begin
				c1[7] = 1'b0;
				c2[7] = 1'b0;
				if (out_code >= kcc_pkg::CODE_JIS_AT_H) begin
					emit(c1);
					emit(c2);
				end else if (out_code == kcc_pkg::CODE_EUC) begin
					emit(c1 | 8'h80);
					emit(c2 | 8'h80);
				end else begin
					c1 = c1 - 8'h20;
					c2 = c2 - 8'h20;
					if (!c1[0])
						c2 = c2 + 8'd94;
					if (c1 == 8'h00)
						c1 = 8'h80;
					else
						c1 = ((c1 - 8'd1) >> 1) + 8'h81;
					c2 = c2 + 8'h3f;
					if (c1 > 8'h9f)
						c1 = c1 + 8'h40;
					if (c2 > 8'h7e)
						c2 = c2 + 8'd1;
					emit(c1);
					emit(c2);
				end
			end else begin
				// high SJIS leads fold down before the row math
				if (c1 > 8'h9f)
					c1 = c1 - 8'h40;
				c1 = (c1 - 8'h81) << 1;
				if (c2 > 8'h7e)
					c2 = c2 - 8'd1;
				if (c2 > 8'h9d) begin
					c2 = c2 - 8'h9d;
					c1 = c1 + 8'd2;
				end else begin
					c2 = c2 - 8'h3f;
					c1 = c1 + 8'd1;
				end
				if (out_code == kcc_pkg::CODE_EUC) begin
					emit(c1 + 8'ha0);
					emit(c2 + 8'ha0);
				end else begin
					emit(c1 + 8'h20);
					emit(c2 + 8'h20);
				end
			end
		endfunction

		function void note_input(logic [7:0] c);
			run = {};
			if (in_code >= kcc_pkg::CODE_JIS_AT_H) begin
				case (mode)
					kcc_pkg::MODE_LEAD: begin
						// stray escape between the two halves is dropped
						if (c != kcc_pkg::ESC_BYTE) begin
							mode = kcc_pkg::MODE_TRAIL;
							convert_pair(lead, c);
						end
					end
					kcc_pkg::MODE_TRAIL: begin
						if (c == kcc_pkg::ESC_BYTE)
							mode = kcc_pkg::MODE_KESC;
						else if (bs_en && c == kcc_pkg::BS_BYTE)
							emit(c);
						else if (c < kcc_pkg::SPACE_BYTE || c == kcc_pkg::DEL_BYTE)
							leave_kanji(c);
						else begin
							mode = kcc_pkg::MODE_LEAD;
							lead = c;
						end
					end
					kcc_pkg::MODE_ESC: begin
						if (c == kcc_pkg::DOLLAR_BYTE)
							mode = kcc_pkg::MODE_ESCDL;
						else if (c == kcc_pkg::PAREN_BYTE)
							mode = kcc_pkg::MODE_ESCPAR;
						else begin
							emit(kcc_pkg::ESC_BYTE);
							emit(c);
							mode = kcc_pkg::MODE_ASCII;
						end
					end
					kcc_pkg::MODE_KESC: begin
						if (c == kcc_pkg::PAREN_BYTE)
							mode = kcc_pkg::MODE_KESCPR;
						else if (c == kcc_pkg::DOLLAR_BYTE)
							mode = kcc_pkg::MODE_KESCDL;
						else begin
							emit(kcc_pkg::ESC_BYTE);
							emit(c);
							mode = kcc_pkg::MODE_LEAD;
						end
					end
					kcc_pkg::MODE_ESCDL: begin
						mode = kcc_pkg::MODE_TRAIL;
						kanji_in();
					end
					kcc_pkg::MODE_KESCPR: begin
						mode = kcc_pkg::MODE_ASCII;
						kanji_out();
					end
					kcc_pkg::MODE_ESCPAR: mode = kcc_pkg::MODE_ASCII;
					kcc_pkg::MODE_KESCDL: mode = kcc_pkg::MODE_TRAIL;
					default: begin
						if (c == kcc_pkg::ESC_BYTE)
							mode = kcc_pkg::MODE_ESC;
						else begin
							mode = kcc_pkg::MODE_ASCII;
							emit(c);
						end
					end
				endcase
			end else begin
				case (mode)
					kcc_pkg::MODE_LEAD: begin
						mode = kcc_pkg::MODE_TRAIL;
						convert_pair(lead, c);
					end
					kcc_pkg::MODE_TRAIL: begin
						if (c[7]) begin
							mode = kcc_pkg::MODE_LEAD;
							lead = c;
						end else if (bs_en && c == kcc_pkg::BS_BYTE)
							emit(c);
						else
							leave_kanji(c);
					end
					// escape states left over from a JIS setting decode as ascii
					default: begin
						if (c[7]) begin
							mode = kcc_pkg::MODE_LEAD;
							lead = c;
							kanji_in();
						end else begin
							mode = kcc_pkg::MODE_ASCII;
							emit(c);
						end
					end
				endcase
			end
			foreach (run[k])
				expected_q.push_back('{data: run[k], last: (k == run.size() - 1)});
		endfunction

		function void check_result(logic [7:0] b, logic l);
			out_word_t w;
			if (expected_q.size() == 0) begin
				$error("out_byte: expected nothing, got 0x%02h", b);
				errors++;
				return;
			end
			w = expected_q.pop_front();
			if (b !== w.data) begin
				$error("out_byte: expected 0x%02h, got 0x%02h", w.data, b);
				errors++;
			end
			if (l !== w.last) begin
				$error("last_of_run: expected %0d, got %0d", w.last, l);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [2:0] cfg_wdata;

	kcc_in_if  in_chan();
	kcc_out_if out_chan();

	kanji_scoreboard sb = new();

	bit idle_on;
	bit hold_req;
	bit hold_done;
	int stall_left;
	int sent_bytes;

	kanji_code_converter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_chan  (in_chan),
		.out_chan (out_chan)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_kanji_code_converter_top NOT OK");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		out_chan.ready = 1'b0;
		stall_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				stall_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (stall_left > 0) begin
				out_chan.ready = 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_chan.ready = 1'b0;
				stall_left = $urandom_range(0, 8);
			end else
				out_chan.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
			sb.check_result(out_chan.out_byte, out_chan.last_of_run);
	end

	// all driving tasks start and end just after a falling edge
	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_chan.valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_chan.valid = 1'b1;
		in_chan.in_byte = b;
		do @(posedge clk); while (in_chan.ready !== 1'b1);
		sb.note_input(b);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [2:0] ic, input logic [2:0] oc, input logic bs);
		write_reg(kcc_pkg::REG_INPUT_CODE, ic);
		write_reg(kcc_pkg::REG_OUTPUT_CODE, oc);
		write_reg(kcc_pkg::REG_KANJI_BS_EN, {2'b00, bs});
	endtask

	// drain: bytes that produce nothing may still be in the pipe, so keep waiting after the scoreboard empties
	task automatic settle();
		in_chan.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic feed_plain(input int count);
		int         stop_at;
		int         kind;
		logic [7:0] hi;
		logic [7:0] lo;
		stop_at = sent_bytes + count;
		while (sent_bytes < stop_at) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				if (sb.in_code == kcc_pkg::CODE_SJIS) begin
					if ($urandom_range(0, 1))
						hi = 8'($urandom_range(8'h81, 8'h9f));
					else
						hi = 8'($urandom_range(8'he0, 8'hfc));
					lo = 8'($urandom_range(8'h40, 8'hfc));
				end else begin
					hi = 8'($urandom_range(8'ha1, 8'hfe));
					lo = 8'($urandom_range(8'ha1, 8'hfe));
				end
				send_byte(hi);
				send_byte(lo);
			end else if (kind <= 7)
				send_byte(8'($urandom_range(8'h20, 8'h7e)));
			else if (kind == 8)
				send_byte(kcc_pkg::BS_BYTE);
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_letter();
		int pick;
		pick = $urandom_range(0, 2);
		send_byte(pick == 0 ? kcc_pkg::H_BYTE : pick == 1 ? kcc_pkg::J_BYTE : kcc_pkg::B_BYTE);
	endtask

	task automatic feed_jis(input int count);
		int stop_at;
		int kind;
		stop_at = sent_bytes + count;
		while (sent_bytes < stop_at) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				// kanji run: shift in, a few pairs, then some way out
				send_byte(kcc_pkg::ESC_BYTE);
				send_byte(kcc_pkg::DOLLAR_BYTE);
				send_byte($urandom_range(0, 1) ? kcc_pkg::AT_BYTE : kcc_pkg::B_BYTE);
				repeat ($urandom_range(1, 3)) begin
					send_byte(8'($urandom_range(8'h21, 8'h7e)));
					if ($urandom_range(0, 9) == 0)
						send_byte(kcc_pkg::ESC_BYTE);
					send_byte(8'($urandom_range(8'h21, 8'h7e)));
					if ($urandom_range(0, 7) == 0)
						send_byte(kcc_pkg::BS_BYTE);
				end
				case ($urandom_range(0, 5))
					0, 1: begin
						send_byte(kcc_pkg::ESC_BYTE);
						send_byte(kcc_pkg::PAREN_BYTE);
						send_letter();
					end
					2: send_byte(8'($urandom_range(0, 8'h1f)));
					3: send_byte(kcc_pkg::DEL_BYTE);
					4: begin
						send_byte(kcc_pkg::ESC_BYTE);
						send_byte(kcc_pkg::DOLLAR_BYTE);
						send_byte(8'($urandom_range(0, 255)));
					end
					default: begin
						send_byte(kcc_pkg::ESC_BYTE);
						send_byte(8'($urandom_range(0, 255)));
					end
				endcase
			end else if (kind <= 7) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(8'h20, 8'h7e)));
			end else if (kind == 8) begin
				send_byte(kcc_pkg::ESC_BYTE);
				send_byte(kcc_pkg::PAREN_BYTE);
				send_letter();
			end else begin
				if ($urandom_range(0, 1))
					send_byte(kcc_pkg::ESC_BYTE);
				send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic run_phase(input logic [2:0] ic, input logic [2:0] oc, input logic bs,
			input int count);
		configure(ic, oc, bs);
		if (ic >= kcc_pkg::CODE_JIS_AT_H)
			feed_jis(count);
		else
			feed_plain(count);
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kcc_pkg::REG_INPUT_CODE;
		cfg_wdata = kcc_pkg::CODE_EUC;
		in_chan.valid = 1'b0;
		in_chan.in_byte = 8'h00;
		idle_on = 1'b1;
		hold_req = 1'b0;
		sent_bytes = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// EUC in, JIS out: shift escapes, extreme bytes, backspace kept inside kanji
		configure(kcc_pkg::CODE_EUC, kcc_pkg::CODE_JIS_AT_H, 1'b1);
		send_byte(8'h41);
		send_byte(8'hff);
		send_byte(8'hfe);
		send_byte(kcc_pkg::BS_BYTE);
		send_byte(8'h00);
		settle();

		// SJIS high lead fold, then a low lead
		configure(kcc_pkg::CODE_SJIS, kcc_pkg::CODE_EUC, 1'b0);
		send_byte(8'he0);
		send_byte(8'h40);
		send_byte(8'h88);
		send_byte(8'h9f);
		settle();

		// JIS in: stray escape mid-pair, unknown escapes in and out of kanji
		configure(kcc_pkg::CODE_JIS_B_B, kcc_pkg::CODE_SJIS, 1'b0);
		send_byte(kcc_pkg::ESC_BYTE);
		send_byte(kcc_pkg::DOLLAR_BYTE);
		send_byte(kcc_pkg::B_BYTE);
		send_byte(8'h30);
		send_byte(kcc_pkg::ESC_BYTE);
		send_byte(8'h21);
		send_byte(kcc_pkg::ESC_BYTE);
		send_byte(8'h41);
		send_byte(8'h22);
		send_byte(kcc_pkg::ESC_BYTE);
		send_byte(kcc_pkg::PAREN_BYTE);
		send_byte(kcc_pkg::B_BYTE);
		send_byte(kcc_pkg::ESC_BYTE);
		send_byte(8'h78);
		send_byte(kcc_pkg::ESC_BYTE);
		settle();
		// leave the decoder in its escape state and switch to a plain input code
		write_reg(kcc_pkg::REG_INPUT_CODE, kcc_pkg::CODE_EUC);
		send_byte(8'h41);
		settle();

		run_phase(kcc_pkg::CODE_EUC, kcc_pkg::CODE_SJIS, 1'b0, 40);
		hold_req = 1'b1;
		run_phase(kcc_pkg::CODE_SJIS, kcc_pkg::CODE_JIS_B_J, 1'b1, 40);
		run_phase(kcc_pkg::CODE_JIS_AT_H, kcc_pkg::CODE_EUC, 1'b1, 40);
		run_phase(kcc_pkg::CODE_JIS_B_J, kcc_pkg::CODE_JIS_B_H, 1'b0, 40);
		run_phase(kcc_pkg::CODE_JIS_AT_J, kcc_pkg::CODE_SJIS, 1'b0, 40);
		run_phase(kcc_pkg::CODE_SJIS, kcc_pkg::CODE_SJIS, 1'b1, 30);
		run_phase(kcc_pkg::CODE_JIS_B_B, kcc_pkg::CODE_JIS_B_B, 1'b1, 30);
		run_phase(kcc_pkg::CODE_EUC, kcc_pkg::CODE_JIS_AT_B, 1'b0, 30);
		idle_on = 1'b0;
		run_phase(kcc_pkg::CODE_JIS_B_H, kcc_pkg::CODE_JIS_AT_J, 1'b1, 35);

		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_kanji_code_converter_top OK");
		else
			$display("tb_kanji_code_converter_top NOT OK");
		$finish;
	end

endmodule
